>>> rtl/vfa_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the three-component vector alu
// no dependencies

package vfa_pkg;

   typedef enum logic [3:0] {
      FN_CROSS  = 4'd0,
      FN_NORM   = 4'd1,
      FN_MAG    = 4'd2,
      FN_DIST   = 4'd3,
      FN_MAGSQ  = 4'd4,
      FN_DISTSQ = 4'd5,
      FN_DOT    = 4'd6,
      FN_BCAST  = 4'd7,
      FN_SADD   = 4'd8,
      FN_SSUB   = 4'd9,
      FN_SMUL   = 4'd10,
      FN_SDIV   = 4'd11,
      FN_VADD   = 4'd12,
      FN_VSUB   = 4'd13,
      FN_VMUL   = 4'd14,
      FN_VDIV   = 4'd15
   } func_type;

   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      func_type   func;
      logic [2:0] o_zero;
   } vfa_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } vfa_fifo_stat_type;

   // lanes, sum of lanes, a and second operand
   function automatic int work_width(input int w);
      return 3 * (2 * w + 3) + (2 * w + 4) + 6 * w;
   endfunction

endpackage

>>> rtl/vec3_fixed_point_alu.sv
`timescale 1ns / 1ps
// top level of the three-component fixed point vector alu
// depends on vfa_pkg, vfa_front, vfa_fifo and vfa_back

// Takes one transaction per clock while req_tready is high and returns one result
// transaction for each, in order. On its way to rsp_tvalid a result passes four
// front stages, the queue, the back end's input register, the square root
// pipeline, one stage per root bit (WORD_WIDTH + 2), three divider lanes, one
// stage per quotient bit (WORD_WIDTH + FRAC_BITS), and the output register. A
// four-entry queue sits between the multiplier front end and the root and divider
// back end, so input keeps flowing for a few transactions while a result waits to
// be taken.

module vec3_fixed_point_alu #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   // ax, ay, az, bx, by, bz, scalar_in
   input  logic [((7*WORD_WIDTH+7)/8)*8-1:0]               req_tdata,
   // func
   input  logic [3:0]                                      req_tuser,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   // res_x, res_y, res_z, res_scalar
   output logic [((4*WORD_WIDTH+7)/8)*8-1:0]               rsp_tdata,
   // overflow, divide_by_zero
   output logic [1:0]                                      rsp_tuser
);
   import vfa_pkg::*;

   localparam int W     = WORD_WIDTH;
   localparam int DW    = work_width(W);
   localparam int OUT_W = ((4 * W + 7) / 8) * 8;

   logic                f_valid, f_pop;
   vfa_ctl_type         f_ctl, q_ctl;
   logic [DW-1:0]       f_data, q_data;
   vfa_fifo_stat_type   fifo_stat;
   logic signed [W-1:0] res_x, res_y, res_z, res_scalar;
   logic                overflow, divide_by_zero;

   vfa_front #(.WORD_WIDTH(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .func      (req_tuser),
      .ax        (req_tdata[0*W +: W]),
      .ay        (req_tdata[1*W +: W]),
      .az        (req_tdata[2*W +: W]),
      .bx        (req_tdata[3*W +: W]),
      .by        (req_tdata[4*W +: W]),
      .bz        (req_tdata[5*W +: W]),
      .scalar_in (req_tdata[6*W +: W]),
      .fifo_stat (fifo_stat),
      .out_valid (f_valid),
      .out_ctl   (f_ctl),
      .out_data  (f_data)
   );

   vfa_fifo #(.DATA_WIDTH(DW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_ctl  (f_ctl),
      .push_data (f_data),
      .pop       (f_pop),
      .pop_ctl   (q_ctl),
      .pop_data  (q_data),
      .stat      (fifo_stat)
   );

   vfa_back #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_stat      (fifo_stat),
      .pop            (f_pop),
      .in_ctl         (q_ctl),
      .in_data        (q_data),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .res_x          (res_x),
      .res_y          (res_y),
      .res_z          (res_z),
      .res_scalar     (res_scalar),
      .overflow       (overflow),
      .divide_by_zero (divide_by_zero)
   );

   assign rsp_tdata = OUT_W'({res_scalar, res_z, res_y, res_x});
   assign rsp_tuser = {divide_by_zero, overflow};

   assert property (@(posedge clock) disable iff (reset)
      !(fifo_stat.full && fifo_stat.empty))
      else $error("queue reports full and empty at once");

   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> fifo_stat.full)
      else $error("input stalled while the queue has room");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata[4*W-1:3*W] == '0))
      else $error("scalar divide by zero with nonzero scalar result");

endmodule

>>> rtl/vfa_front.sv
`timescale 1ns / 1ps
// front pipeline: decode, operand select, products and lane sums
// depends on vfa_pkg

module vfa_front #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [3:0]                      func,
   input  logic signed [WORD_WIDTH-1:0]    ax,
   input  logic signed [WORD_WIDTH-1:0]    ay,
   input  logic signed [WORD_WIDTH-1:0]    az,
   input  logic signed [WORD_WIDTH-1:0]    bx,
   input  logic signed [WORD_WIDTH-1:0]    by,
   input  logic signed [WORD_WIDTH-1:0]    bz,
   input  logic signed [WORD_WIDTH-1:0]    scalar_in,
   input  vfa_pkg::vfa_fifo_stat_type      fifo_stat,
   output logic                            out_valid,
   output vfa_pkg::vfa_ctl_type            out_ctl,
   output logic [vfa_pkg::work_width(WORD_WIDTH)-1:0] out_data
);
   import vfa_pkg::*;

   localparam int W  = WORD_WIDTH;
   localparam int MW = W + 1;
   localparam int PW = 2 * W + 2;
   localparam int T  = 2 * W + 3;
   localparam int S  = 2 * W + 4;

   logic                 en;
   func_type             fn;
   logic signed [W-1:0]  a_c [3];
   logic signed [W-1:0]  b_c [3];
   logic signed [W-1:0]  o_c [3];
   logic signed [MW-1:0] d_c [3];
   logic signed [MW-1:0] as_c [3];
   logic signed [MW-1:0] mx_c [6];
   logic signed [MW-1:0] my_c [6];
   logic [2:0]           oz_c;

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   vfa_ctl_type          s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff;
   logic signed [MW-1:0] s1_mx_ff [6];
   logic signed [MW-1:0] s1_my_ff [6];
   logic signed [MW-1:0] s1_as_ff [3];
   logic signed [MW-1:0] s2_as_ff [3];
   logic signed [W-1:0]  s1_a_ff [3];
   logic signed [W-1:0]  s2_a_ff [3];
   logic signed [W-1:0]  s3_a_ff [3];
   logic signed [W-1:0]  s4_a_ff [3];
   logic signed [W-1:0]  s1_o_ff [3];
   logic signed [W-1:0]  s2_o_ff [3];
   logic signed [W-1:0]  s3_o_ff [3];
   logic signed [W-1:0]  s4_o_ff [3];
   logic signed [PW-1:0] s2_p_ff [6];
   logic signed [T-1:0]  s3_t_ff [3];
   logic signed [T-1:0]  s4_t_ff [3];
   logic signed [S-1:0]  s4_sum_ff;
   logic                 s3_addsub;

   assign en       = !(s4_valid_ff && fifo_stat.full);
   assign in_ready = en;

   always_comb begin
      fn     = func_type'(func);
      a_c[0] = ax;
      a_c[1] = ay;
      a_c[2] = az;
      b_c[0] = bx;
      b_c[1] = by;
      b_c[2] = bz;
      for (int i = 0; i < 3; i++) begin
         o_c[i]  = (fn >= FN_VADD) ? b_c[i] : scalar_in;
         d_c[i]  = MW'(a_c[i]) - MW'(b_c[i]);
         as_c[i] = (fn == FN_SSUB || fn == FN_VSUB) ? MW'(a_c[i]) - MW'(o_c[i])
                                                     : MW'(a_c[i]) + MW'(o_c[i]);
         oz_c[i] = (o_c[i] == '0);
      end
      for (int j = 0; j < 6; j++) begin
         mx_c[j] = '0;
         my_c[j] = '0;
      end
      unique case (fn)
         FN_CROSS: begin
            mx_c[0] = MW'(ay); my_c[0] = MW'(bz);
            mx_c[1] = MW'(az); my_c[1] = MW'(by);
            mx_c[2] = MW'(az); my_c[2] = MW'(bx);
            mx_c[3] = MW'(ax); my_c[3] = MW'(bz);
            mx_c[4] = MW'(ax); my_c[4] = MW'(by);
            mx_c[5] = MW'(ay); my_c[5] = MW'(bx);
         end
         FN_NORM, FN_MAG, FN_MAGSQ: begin
            for (int i = 0; i < 3; i++) begin
               mx_c[2*i] = MW'(a_c[i]);
               my_c[2*i] = MW'(a_c[i]);
            end
         end
         FN_DIST, FN_DISTSQ: begin
            for (int i = 0; i < 3; i++) begin
               mx_c[2*i] = d_c[i];
               my_c[2*i] = d_c[i];
            end
         end
         FN_DOT, FN_VMUL: begin
            for (int i = 0; i < 3; i++) begin
               mx_c[2*i] = MW'(a_c[i]);
               my_c[2*i] = MW'(b_c[i]);
            end
         end
         FN_SMUL: begin
            for (int i = 0; i < 3; i++) begin
               mx_c[2*i] = MW'(a_c[i]);
               my_c[2*i] = MW'(scalar_in);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   assign s3_addsub = (s2_ctl_ff.func == FN_SADD) || (s2_ctl_ff.func == FN_SSUB) ||
                      (s2_ctl_ff.func == FN_VADD) || (s2_ctl_ff.func == FN_VSUB);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ctl_ff.func   <= fn;
         s1_ctl_ff.o_zero <= oz_c;
         s2_ctl_ff        <= s1_ctl_ff;
         s3_ctl_ff        <= s2_ctl_ff;
         s4_ctl_ff        <= s3_ctl_ff;
         for (int j = 0; j < 6; j++) begin
            s1_mx_ff[j] <= mx_c[j];
            s1_my_ff[j] <= my_c[j];
            s2_p_ff[j]  <= s1_mx_ff[j] * s1_my_ff[j];
         end
         for (int i = 0; i < 3; i++) begin
            s1_as_ff[i] <= as_c[i];
            s2_as_ff[i] <= s1_as_ff[i];
            s1_a_ff[i]  <= a_c[i];
            s2_a_ff[i]  <= s1_a_ff[i];
            s3_a_ff[i]  <= s2_a_ff[i];
            s4_a_ff[i]  <= s3_a_ff[i];
            s1_o_ff[i]  <= o_c[i];
            s2_o_ff[i]  <= s1_o_ff[i];
            s3_o_ff[i]  <= s2_o_ff[i];
            s4_o_ff[i]  <= s3_o_ff[i];
            s3_t_ff[i]  <= s3_addsub ? T'(s2_as_ff[i])
                                     : T'(s2_p_ff[2*i]) - T'(s2_p_ff[2*i+1]);
            s4_t_ff[i]  <= s3_t_ff[i];
         end
         s4_sum_ff <= S'(s3_t_ff[0]) + S'(s3_t_ff[1]) + S'(s3_t_ff[2]);
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_ctl   = s4_ctl_ff;
   assign out_data  = {s4_t_ff[2], s4_t_ff[1], s4_t_ff[0], s4_sum_ff,
                       s4_a_ff[2], s4_a_ff[1], s4_a_ff[0],
                       s4_o_ff[2], s4_o_ff[1], s4_o_ff[0]};

endmodule

>>> rtl/vfa_fifo.sv
`timescale 1ns / 1ps
// short queue between the front and back pipelines
// depends on vfa_pkg

module vfa_fifo #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  vfa_pkg::vfa_ctl_type       push_ctl,
   input  logic [DATA_WIDTH-1:0]      push_data,
   input  logic                       pop,
   output vfa_pkg::vfa_ctl_type       pop_ctl,
   output logic [DATA_WIDTH-1:0]      pop_data,
   output vfa_pkg::vfa_fifo_stat_type stat
);
   import vfa_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   vfa_ctl_type           ctl_mem [FIFO_DEPTH];
   logic [DATA_WIDTH-1:0] data_mem [FIFO_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  do_push, do_pop;

   assign stat.full  = (count_ff == CNT_W'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ctl_mem[wr_ptr_ff]  <= push_ctl;
         data_mem[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_ctl  = ctl_mem[rd_ptr_ff];
   assign pop_data = data_mem[rd_ptr_ff];

endmodule

>>> rtl/vfa_back.sv
`timescale 1ns / 1ps
// back pipeline: square root stages, three divider lanes, rounding and saturation
// depends on vfa_pkg

module vfa_back #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  vfa_pkg::vfa_fifo_stat_type   fifo_stat,
   output logic                         pop,
   input  vfa_pkg::vfa_ctl_type         in_ctl,
   input  logic [vfa_pkg::work_width(WORD_WIDTH)-1:0] in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [WORD_WIDTH-1:0] res_x,
   output logic signed [WORD_WIDTH-1:0] res_y,
   output logic signed [WORD_WIDTH-1:0] res_z,
   output logic signed [WORD_WIDTH-1:0] res_scalar,
   output logic                         overflow,
   output logic                         divide_by_zero
);
   import vfa_pkg::*;

   localparam int W = WORD_WIDTH;
   localparam int F = FRAC_BITS;
   localparam int T = 2 * W + 3;
   localparam int S = 2 * W + 4;
   localparam int K = W + 2;
   localparam int Q = W + F;
   localparam int D = K + Q;

   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [S:0] XMAX = {{(S+2-W){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [S:0] XMIN = {{(S+2-W){1'b1}}, {(W-1){1'b0}}};
   localparam logic signed [S:0] HALF = (S+1)'(1) << (F - 1);

   logic                en;
   logic signed [T-1:0] t_in [3];
   logic signed [S-1:0] sum_in;
   logic signed [W-1:0] a_in [3];
   logic signed [W-1:0] o_in [3];

   logic                vld_ff  [0:D];
   vfa_ctl_type         ctl_ff  [0:D];
   logic signed [T-1:0] t_ff    [0:D][3];
   logic signed [S-1:0] sum_ff  [0:D];
   logic signed [W-1:0] a_ff    [0:D][3];
   logic signed [W-1:0] o_ff    [0:D][3];
   logic [S-1:0]        rad_ff  [0:D];
   logic [K+1:0]        srem_ff [0:D];
   logic [K-1:0]        root_ff [0:D];
   logic [K-1:0]        dv_ff   [0:D][3];
   logic [Q-1:0]        num_ff  [0:D][3];
   logic [K-1:0]        drem_ff [0:D][3];
   logic [Q-1:0]        quo_ff  [0:D][3];

   logic [S-1:0]        rad_nx  [0:D-1];
   logic [K+1:0]        srem_nx [0:D-1];
   logic [K-1:0]        root_nx [0:D-1];
   logic [K-1:0]        dv_nx   [0:D-1][3];
   logic [Q-1:0]        num_nx  [0:D-1][3];
   logic [K-1:0]        drem_nx [0:D-1][3];
   logic [Q-1:0]        quo_nx  [0:D-1][3];

   logic signed [W-1:0] v_c [3];
   logic signed [W-1:0] sc_c;
   logic [2:0]          ov_v;
   logic                ov_s, dz_c;

   logic                out_valid_ff;
   logic signed [W-1:0] res_ff [4];
   logic                ovf_ff, dz_ff;

   function automatic logic signed [W-1:0] sat(input logic signed [S:0] x, output logic ov);
      ov = 1'b0;
      if (x > XMAX) begin
         ov = 1'b1;
         return WMAX;
      end
      if (x < XMIN) begin
         ov = 1'b1;
         return WMIN;
      end
      return x[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] rsat(input logic signed [S:0] x, output logic ov);
      logic signed [S:0] y;
      y = (x + HALF) >>> F;
      return sat(y, ov);
   endfunction

   function automatic logic signed [W-1:0] dsat(input logic [Q-1:0] q, input logic neg,
                                                output logic ov);
      logic signed [S:0] x;
      x = $signed({{(S+1-Q){1'b0}}, q});
      if (neg) x = -x;
      return sat(x, ov);
   endfunction

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
      return v[W-1] ? (~v + 1'b1) : v;
   endfunction

   assign en  = !out_valid_ff || out_ready;
   assign pop = en && !fifo_stat.empty;

   assign {t_in[2], t_in[1], t_in[0], sum_in, a_in[2], a_in[1], a_in[0],
           o_in[2], o_in[1], o_in[0]} = in_data;

   // per stage step: square root first, then restoring division
   always_comb begin
      logic [K+3:0] r4;
      logic [K+3:0] trial;
      logic [K:0]   r;
      for (int k = 0; k < D; k++) begin
         r4    = '0;
         trial = '0;
         r     = '0;
         rad_nx[k]  = rad_ff[k];
         srem_nx[k] = srem_ff[k];
         root_nx[k] = root_ff[k];
         for (int i = 0; i < 3; i++) begin
            dv_nx[k][i]   = dv_ff[k][i];
            num_nx[k][i]  = num_ff[k][i];
            drem_nx[k][i] = drem_ff[k][i];
            quo_nx[k][i]  = quo_ff[k][i];
         end
         if (k < K) begin
            r4    = {srem_ff[k], rad_ff[k][S-1:S-2]};
            trial = (K+4)'({root_ff[k], 2'b01});
            rad_nx[k] = {rad_ff[k][S-3:0], 2'b00};
            if (r4 >= trial) begin
               srem_nx[k] = (K+2)'(r4 - trial);
               root_nx[k] = {root_ff[k][K-2:0], 1'b1};
            end else begin
               srem_nx[k] = r4[K+1:0];
               root_nx[k] = {root_ff[k][K-2:0], 1'b0};
            end
         end
         if (k == K - 1) begin
            for (int i = 0; i < 3; i++) begin
               dv_nx[k][i]   = (ctl_ff[k].func == FN_NORM) ? root_nx[k]
                                                           : K'(mag(o_ff[k][i]));
               num_nx[k][i]  = {mag(a_ff[k][i]), {F{1'b0}}};
               drem_nx[k][i] = '0;
               quo_nx[k][i]  = '0;
            end
         end
         if (k >= K) begin
            for (int i = 0; i < 3; i++) begin
               r = {drem_ff[k][i], num_ff[k][i][Q-1]};
               num_nx[k][i] = {num_ff[k][i][Q-2:0], 1'b0};
               if (r >= {1'b0, dv_ff[k][i]}) begin
                  drem_nx[k][i] = K'(r - {1'b0, dv_ff[k][i]});
                  quo_nx[k][i]  = {quo_ff[k][i][Q-2:0], 1'b1};
               end else begin
                  drem_nx[k][i] = r[K-1:0];
                  quo_nx[k][i]  = {quo_ff[k][i][Q-2:0], 1'b0};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= D; k++) vld_ff[k] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= !fifo_stat.empty;
         for (int k = 0; k < D; k++) vld_ff[k+1] <= vld_ff[k];
         out_valid_ff <= vld_ff[D];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff[0]  <= in_ctl;
         sum_ff[0]  <= sum_in;
         rad_ff[0]  <= sum_in;
         srem_ff[0] <= '0;
         root_ff[0] <= '0;
         for (int i = 0; i < 3; i++) begin
            t_ff[0][i]    <= t_in[i];
            a_ff[0][i]    <= a_in[i];
            o_ff[0][i]    <= o_in[i];
            dv_ff[0][i]   <= '0;
            num_ff[0][i]  <= '0;
            drem_ff[0][i] <= '0;
            quo_ff[0][i]  <= '0;
         end
         for (int k = 0; k < D; k++) begin
            ctl_ff[k+1]  <= ctl_ff[k];
            sum_ff[k+1]  <= sum_ff[k];
            rad_ff[k+1]  <= rad_nx[k];
            srem_ff[k+1] <= srem_nx[k];
            root_ff[k+1] <= root_nx[k];
            for (int i = 0; i < 3; i++) begin
               t_ff[k+1][i]    <= t_ff[k][i];
               a_ff[k+1][i]    <= a_ff[k][i];
               o_ff[k+1][i]    <= o_ff[k][i];
               dv_ff[k+1][i]   <= dv_nx[k][i];
               num_ff[k+1][i]  <= num_nx[k][i];
               drem_ff[k+1][i] <= drem_nx[k][i];
               quo_ff[k+1][i]  <= quo_nx[k][i];
            end
         end
      end
   end

   // rounding, saturation and special cases
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v_c[i]  = '0;
         ov_v[i] = 1'b0;
      end
      sc_c = '0;
      ov_s = 1'b0;
      dz_c = 1'b0;
      unique case (ctl_ff[D].func)
         FN_CROSS, FN_SMUL, FN_VMUL: begin
            for (int i = 0; i < 3; i++)
               v_c[i] = rsat((S+1)'(t_ff[D][i]), ov_v[i]);
         end
         FN_NORM: begin
            if (root_ff[D] != '0) begin
               for (int i = 0; i < 3; i++)
                  v_c[i] = dsat(quo_ff[D][i], a_ff[D][i][W-1], ov_v[i]);
            end
         end
         FN_MAG, FN_DIST: begin
            sc_c = sat($signed({{(S+1-K){1'b0}}, root_ff[D]}), ov_s);
         end
         FN_MAGSQ, FN_DISTSQ, FN_DOT: begin
            sc_c = rsat((S+1)'(sum_ff[D]), ov_s);
         end
         FN_BCAST: begin
            for (int i = 0; i < 3; i++) v_c[i] = o_ff[D][0];
         end
         FN_SADD, FN_SSUB, FN_VADD, FN_VSUB: begin
            for (int i = 0; i < 3; i++)
               v_c[i] = sat((S+1)'(t_ff[D][i]), ov_v[i]);
         end
         FN_SDIV: begin
            for (int i = 0; i < 3; i++) begin
               if (ctl_ff[D].o_zero[i]) begin
                  v_c[i] = a_ff[D][i][W-1] ? WMIN : WMAX;
                  dz_c   = 1'b1;
               end else begin
                  v_c[i] = dsat(quo_ff[D][i], a_ff[D][i][W-1] ^ o_ff[D][i][W-1], ov_v[i]);
               end
            end
         end
         FN_VDIV: begin
            for (int i = 0; i < 3; i++) begin
               if (!ctl_ff[D].o_zero[i])
                  v_c[i] = dsat(quo_ff[D][i], a_ff[D][i][W-1] ^ o_ff[D][i][W-1], ov_v[i]);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff[0] <= v_c[0];
         res_ff[1] <= v_c[1];
         res_ff[2] <= v_c[2];
         res_ff[3] <= sc_c;
         ovf_ff    <= (|ov_v) || ov_s;
         dz_ff     <= dz_c;
      end
   end

   assign out_valid      = out_valid_ff;
   assign res_x          = res_ff[0];
   assign res_y          = res_ff[1];
   assign res_z          = res_ff[2];
   assign res_scalar     = res_ff[3];
   assign overflow       = ovf_ff;
   assign divide_by_zero = dz_ff;

endmodule
